[rtl/core/ica_pkg.sv]
package ica_pkg;

   // Port widths fixed by the interface.
   localparam int DATA_W = 64;
   localparam int FRAC_W = 32;
   localparam int CMD_W  = 3;
   localparam int STS_W  = 2;

   // Defaults for the top level parameters.
   localparam int DEF_WIDTH     = 64;
   localparam int DEF_FRAC_BITS = 32;

   // Multiplier bits consumed per cycle by each multiply lane, capped at the operand width.
   localparam int MUL_CHUNK = 16;

   // Operation codes.
   localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
   localparam logic [CMD_W-1:0] CMD_SUB = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MUL = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DIV = 3'd4;
   localparam logic [CMD_W-1:0] CMD_MOD = 3'd5;
   localparam logic [CMD_W-1:0] CMD_POW = 3'd6;

   // Status codes.
   localparam logic [STS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STS_W-1:0] STS_INVALID  = 2'd1;
   localparam logic [STS_W-1:0] STS_OVERFLOW = 2'd2;
   localparam logic [STS_W-1:0] STS_DIV_ZERO = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul_init_op;
      logic mul_init_pow;
      logic mul_step;
      logic pow_update;
      logic div_step;
      logic out_load;
   } ica_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             b_zero;
      logic             exp_le0;
      logic             e_le1;
   } ica_sts_type;

endpackage

[rtl/core/ica_dp.sv]
module ica_dp import ica_pkg::*; #(
   parameter int WIDTH     = DEF_WIDTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  ica_cmd_type              cmd,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   output ica_sts_type              sts,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic [FRAC_W-1:0]        rsp_fraction,
   output logic                     rsp_negative,
   output logic [STS_W-1:0]         rsp_status
);

   localparam int N  = WIDTH + FRAC_BITS;
   localparam int CH = (WIDTH < MUL_CHUNK) ? WIDTH : MUL_CHUNK;
   localparam logic [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};
   localparam logic [WIDTH-1:0] ONE_VAL = {{(WIDTH-1){1'b0}}, 1'b1};

   logic [CMD_W-1:0] op_ff, op_in;
   logic [WIDTH-1:0] a_ff, a_in, b_ff, b_in;
   logic [WIDTH-1:0] base_ff, base_in, acc_ff, acc_in, e_ff, e_in;
   logic [WIDTH-1:0] cand0_ff, cand0_in, plier0_ff, plier0_in, prod0_ff, prod0_in;
   logic [WIDTH-1:0] cand1_ff, cand1_in, plier1_ff, plier1_in, prod1_ff, prod1_in;
   logic [N-1:0]     qf_ff, qf_in;
   logic [WIDTH-1:0] rem_ff, rem_in, ub_ff, ub_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic             neg_ff, neg_in;
   logic [STS_W-1:0] status_ff, status_in;

   logic [WIDTH-1:0] ld_a, ld_b, ld_ua, ld_ub;
   logic [WIDTH-1:0] mp0, mp1;
   logic [WIDTH:0]   rem_sh;
   logic             rem_ge;
   logic             a_neg, b_neg, b_zero;
   logic [WIDTH-1:0] quot, rmd;
   logic [N+FRAC_W-1:0] frac_wide;
   logic [WIDTH-1:0] r_res;
   logic [FRAC_W-1:0] r_frac;
   logic             r_neg;
   logic [STS_W-1:0] r_status;

   assign ld_a  = req_operand_a[WIDTH-1:0];
   assign ld_b  = req_operand_b[WIDTH-1:0];
   assign ld_ua = ld_a[WIDTH-1] ? -ld_a : ld_a;
   assign ld_ub = ld_b[WIDTH-1] ? -ld_b : ld_b;

   assign mp0 = WIDTH'(cand0_ff * WIDTH'(plier0_ff[CH-1:0]));
   assign mp1 = WIDTH'(cand1_ff * WIDTH'(plier1_ff[CH-1:0]));

   // One restoring division step; the remainder stays below the divisor.
   assign rem_sh = {rem_ff, qf_ff[N-1]};
   assign rem_ge = rem_sh >= {1'b0, ub_ff};

   assign a_neg  = a_ff[WIDTH-1];
   assign b_neg  = b_ff[WIDTH-1];
   assign b_zero = (b_ff == '0);
   assign quot   = qf_ff[N-1:FRAC_BITS];
   assign rmd    = rem_ff;
   assign frac_wide = {qf_ff, {FRAC_W{1'b0}}};

   assign sts.op      = op_ff;
   assign sts.b_zero  = b_zero;
   assign sts.exp_le0 = b_neg || b_zero;
   assign sts.e_le1   = (e_ff[WIDTH-1:1] == '0);

   always_comb begin
      r_res    = '0;
      r_frac   = '0;
      r_neg    = 1'b0;
      r_status = STS_OK;
      unique case (op_ff)
         CMD_ADD: r_res = a_ff + b_ff;
         CMD_SUB: r_res = a_ff - b_ff;
         CMD_MUL: r_res = prod0_ff;
         CMD_DIV: begin
            if (b_zero) begin
               r_status = STS_DIV_ZERO;
            end else if (a_ff == MIN_VAL && (&b_ff)) begin
               r_res    = quot;
               r_status = STS_OVERFLOW;
            end else begin
               r_neg  = (a_neg != b_neg) && (a_ff != '0);
               r_res  = r_neg ? -quot : quot;
               r_frac = frac_wide[FRAC_BITS+FRAC_W-1 -: FRAC_W];
            end
         end
         CMD_MOD: begin
            if (b_zero) begin
               r_status = STS_DIV_ZERO;
            end else begin
               r_res = a_neg ? -rmd : rmd;
            end
         end
         CMD_POW: begin
            if (b_neg || b_zero) begin
               r_res = ONE_VAL;
            end else begin
               r_res = acc_ff;
               if (acc_ff[WIDTH-1] && b_ff != ONE_VAL) begin
                  r_status = STS_OVERFLOW;
               end
            end
         end
         default: r_status = STS_INVALID;
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      e_in      = e_ff;
      cand0_in  = cand0_ff;
      plier0_in = plier0_ff;
      prod0_in  = prod0_ff;
      cand1_in  = cand1_ff;
      plier1_in = plier1_ff;
      prod1_in  = prod1_ff;
      qf_in     = qf_ff;
      rem_in    = rem_ff;
      ub_in     = ub_ff;
      res_in    = res_ff;
      frac_in   = frac_ff;
      neg_in    = neg_ff;
      status_in = status_ff;
      if (cmd.load) begin
         op_in   = req_cmd;
         a_in    = ld_a;
         b_in    = ld_b;
         base_in = ld_a;
         acc_in  = ONE_VAL;
         e_in    = ld_b;
         qf_in   = N'(ld_ua) << FRAC_BITS;
         rem_in  = '0;
         ub_in   = ld_ub;
      end
      if (cmd.mul_init_op) begin
         cand0_in  = a_ff;
         plier0_in = b_ff;
         prod0_in  = '0;
      end
      if (cmd.mul_init_pow) begin
         cand0_in  = base_ff;
         plier0_in = acc_ff;
         prod0_in  = '0;
         cand1_in  = base_ff;
         plier1_in = base_ff;
         prod1_in  = '0;
      end
      if (cmd.mul_step) begin
         prod0_in  = prod0_ff + mp0;
         cand0_in  = cand0_ff << CH;
         plier0_in = plier0_ff >> CH;
         prod1_in  = prod1_ff + mp1;
         cand1_in  = cand1_ff << CH;
         plier1_in = plier1_ff >> CH;
      end
      if (cmd.pow_update) begin
         if (e_ff[0]) begin
            acc_in = prod0_ff;
         end
         base_in = prod1_ff;
         e_in    = e_ff >> 1;
      end
      if (cmd.div_step) begin
         qf_in  = {qf_ff[N-2:0], rem_ge};
         rem_in = rem_ge ? WIDTH'(rem_sh - {1'b0, ub_ff}) : rem_sh[WIDTH-1:0];
      end
      if (cmd.out_load) begin
         res_in    = r_res;
         frac_in   = r_frac;
         neg_in    = r_neg;
         status_in = r_status;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      base_ff   <= base_in;
      acc_ff    <= acc_in;
      e_ff      <= e_in;
      cand0_ff  <= cand0_in;
      plier0_ff <= plier0_in;
      prod0_ff  <= prod0_in;
      cand1_ff  <= cand1_in;
      plier1_ff <= plier1_in;
      prod1_ff  <= prod1_in;
      qf_ff     <= qf_in;
      rem_ff    <= rem_in;
      ub_ff     <= ub_in;
      res_ff    <= res_in;
      frac_ff   <= frac_in;
      neg_ff    <= neg_in;
      status_ff <= status_in;
   end

   assign rsp_result   = DATA_W'(signed'(res_ff));
   assign rsp_fraction = frac_ff;
   assign rsp_negative = neg_ff;
   assign rsp_status   = status_ff;

endmodule

[rtl/core/ica_ctrl.sv]
module ica_ctrl import ica_pkg::*; #(
   parameter int WIDTH     = DEF_WIDTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  ica_sts_type sts,
   output ica_cmd_type cmd
);

   localparam int CH     = (WIDTH < MUL_CHUNK) ? WIDTH : MUL_CHUNK;
   localparam int MSTEPS = (WIDTH + CH - 1) / CH;
   localparam int CNT_W  = $clog2(WIDTH + FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MSTEPS - 1);
   localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(WIDTH - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WIDTH + FRAC_BITS - 1);
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(WIDTH + FRAC_BITS);

   typedef enum logic [2:0] {
      IDLE, DISPATCH, MUL_RUN, POW_INIT, POW_RUN, POW_UPD, DIV_RUN, FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;
   logic [CNT_W-1:0] div_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign div_last  = (sts.op == CMD_MOD) ? MOD_LAST : DIV_LAST;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            cnt_in = '0;
            unique case (sts.op)
               CMD_MUL: begin
                  cmd.mul_init_op = 1'b1;
                  state_in        = MUL_RUN;
               end
               CMD_DIV, CMD_MOD: state_in = sts.b_zero ? FINISH : DIV_RUN;
               CMD_POW: begin
                  if (sts.exp_le0) begin
                     state_in = FINISH;
                  end else begin
                     cmd.mul_init_pow = 1'b1;
                     state_in         = POW_RUN;
                  end
               end
               default: state_in = FINISH;
            endcase
         end
         MUL_RUN: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = FINISH;
            end
         end
         POW_INIT: begin
            cmd.mul_init_pow = 1'b1;
            cnt_in           = '0;
            state_in         = POW_RUN;
         end
         POW_RUN: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = POW_UPD;
            end
         end
         POW_UPD: begin
            cmd.pow_update = 1'b1;
            state_in       = sts.e_le1 ? FINISH : POW_INIT;
         end
         DIV_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == div_last) begin
               state_in = FINISH;
            end
         end
         FINISH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = IDLE;
            end
         end
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> slot_free)
      else $error("result loaded while the output register is still occupied");

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (state_ff == IDLE && req_valid) |=> state_ff == DISPATCH)
      else $error("accepted transfer did not reach dispatch");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("step counter ran past the last division step");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FINISH))
      else $error("result valid raised outside the finish state");
`endif

endmodule

[rtl/core/integer_calculator_alu.sv]
// Sequence: the accepted transfer loads the operands, a dispatch state picks the path, and a
// finish state loads the result. Add, subtract, invalid codes and the early-out cases go from
// dispatch straight to finish; multiply steps the multiply lanes, divide and remainder run the
// one-bit-per-cycle restoring divider, and power runs a multiply round per exponent bit.
// Throughput: one item at a time; a new transfer is taken once the previous result is loaded.
// Reset (synchronous, active high) idles the controller and drops the result valid.
module integer_calculator_alu import ica_pkg::*; #(
   parameter int WIDTH     = DEF_WIDTH,
   parameter int FRAC_BITS = DEF_FRAC_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [CMD_W-1:0]         req_cmd,
   input  logic signed [DATA_W-1:0] req_operand_a,
   input  logic signed [DATA_W-1:0] req_operand_b,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result,
   output logic [FRAC_W-1:0]        rsp_fraction,
   output logic                     rsp_negative,
   output logic [STS_W-1:0]         rsp_status
);

   // The controller sequences each operation: the operands are captured on the
   // accepted transfer, the dispatch state picks the path, and the datapath
   // then iterates. Power uses two multiply lanes and multiply the first one; each
   // takes min(WIDTH, 16) multiplier bits per cycle; power runs one square-and-multiply
   // round per exponent bit. Divide and remainder use a restoring divider on
   // the operand magnitudes, one quotient bit per cycle, extended by FRAC_BITS
   // extra steps for the binary fraction of a divide.
   //
   // The result sits in an output register, so the block returns to idle and
   // takes the next transfer while an earlier result still waits on rsp_stall.

   ica_cmd_type cmd;
   ica_sts_type sts;

   ica_ctrl #(
      .WIDTH     (WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ica_dp #(
      .WIDTH     (WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .req_cmd       (req_cmd),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .sts           (sts),
      .rsp_result    (rsp_result),
      .rsp_fraction  (rsp_fraction),
      .rsp_negative  (rsp_negative),
      .rsp_status    (rsp_status)
   );

endmodule
